>>> rtl/es2cd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// es2cd_pkg
// constants for the epoch seconds to civil date converter: day offsets,
// fixed-point reciprocals for the constant divisions and the month table
// ----------------------------------------------------------------------------
package es2cd_pkg;

	// march-based day shift plus enough whole eras to keep every day count positive
	localparam int unsigned      ERA_BIAS   = 44;
	localparam longint unsigned  SHIFT_DAYS = 64'd719468;
	localparam longint unsigned  OFF_DAYS   = SHIFT_DAYS + 64'(ERA_BIAS) * 64'd146097;
	localparam logic [40:0]      OFF_SEC    = 41'(OFF_DAYS * 64'd86400);

	// 1900 base minus the calendar year of era 0
	localparam logic [15:0]      YEAR_BIAS  = 16'(ERA_BIAS * 400 + 1900);

	localparam logic [9:0]       DIV_675      = 10'd675;
	localparam logic [17:0]      DAYS_PER_ERA = 18'd146097;
	localparam logic [17:0]      LAST_DOE     = 18'd146096;

	// ceil(2^k / d) with k = input bits + ceil(log2 d): exact floor for every input
	localparam logic [34:0] RCP_675   = 35'(((64'd1 << 44) + 64'd674) / 64'd675);
	localparam logic [24:0] RCP_ERA   = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
	localparam logic [24:0] RCP_7     = 25'(((64'd1 << 27) + 64'd6) / 64'd7);
	localparam logic [17:0] RCP_60S   = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
	localparam logic [11:0] RCP_60M   = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
	localparam logic [18:0] RCP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] RCP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] RCP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

	// first day of each month counted from march 1
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

	localparam logic [3:0] MP_JAN            = 4'd10;   // january in march-based months
	localparam logic [8:0] MARCH_DOY_JAN1    = 9'd306;
	localparam logic [8:0] DAYS_BEFORE_MARCH = 9'd59;
	localparam logic [3:0] MONTH_JAN         = 4'd0;

endpackage
`default_nettype wire

>>> rtl/epoch_seconds_to_civil_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date
// signed seconds since 1970-01-01 to proleptic gregorian date and time of day
// ----------------------------------------------------------------------------
// Takes one word per clock while in_ready is high and gives one result word
// per input, in order, through nine register stages: the day split runs
// a 34-bit reciprocal multiply as two partial products, the era and year of
// era steps each sit behind their own multiply, and the month step compares
// against a start table. While out_ready is low, words move up into empty
// stages and in_ready stays high until all nine stages hold a word. Negative
// inputs use floored division, so -1 gives 1969-12-31 23:59:59.

module epoch_seconds_to_civil_date (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [39:0] epoch_seconds,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [4:0]              hour_of_day,
	output logic [5:0]              minute_of_hour,
	output logic [5:0]              second_of_minute,
	output logic [2:0]              weekday,
	output logic signed [15:0]      years_since_1900,
	output logic [3:0]              month_index,
	output logic [4:0]              day_of_month,
	output logic [8:0]              day_of_year
);

	logic [9:1] adv;
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// stage payloads
	logic [40:0] tp_s1;
	logic [51:0] phi_s2, plo_s2;
	logic [33:0] x_s2, x_s3;
	logic [6:0]  lo7_s2, lo7_s3;
	logic [23:0] z_s3, z_s4;
	logic [16:0] sec_s4, sec_s5;
	logic [6:0]  era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [20:0] q7_s4;
	logic [17:0] doe_s5, doe_s6, doe_s7;
	logic [2:0]  wd_s5, wd_s6, wd_s7, wd_s8, wd_s9;
	logic [10:0] mins_s5, mins_s6;
	logic [17:0] n_s6;
	logic [4:0]  hour_s6, hour_s7, hour_s8, hour_s9;
	logic [5:0]  second_s6, second_s7, second_s8, second_s9;
	logic [8:0]  yoe_s7, yoe_s8;
	logic [5:0]  minute_s7, minute_s8, minute_s9;
	logic [8:0]  doy_s8;
	logic        leap_s8;
	logic [15:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  mday_s9;
	logic [8:0]  yday_s9;

	// combinational terms
	logic [40:0] tp_in;
	logic [33:0] x_in;
	logic [51:0] phi_c, plo_c;
	logic [68:0] prod_c;
	logic [33:0] r675_c;
	logic [48:0] pera_c, pwd_c;
	logic [23:0] n7_c;
	logic [23:0] doe_c, wd_c;
	logic [34:0] pmin_c;
	logic [36:0] pa_c, pb_c, py_c;
	logic [22:0] ph_c;
	logic [16:0] sec_c;
	logic [17:0] n_c;
	logic [10:0] minute_c;
	logic [1:0]  q100_c;
	logic [17:0] base_c, doy_c;
	logic        leap_c;
	logic [11:1] ge_c;
	logic [3:0]  mp_c;
	logic        jan_c;
	logic [8:0]  mday_c, yday_c;
	logic [3:0]  month_c;
	logic [15:0] year_c;

	// a stage moves when it is empty or the stage after it moves
	assign adv[9]   = !vld_s9 || out_ready;
	assign adv[8]   = !vld_s8 || adv[9];
	assign adv[7]   = !vld_s7 || adv[8];
	assign adv[6]   = !vld_s6 || adv[7];
	assign adv[5]   = !vld_s5 || adv[6];
	assign adv[4]   = !vld_s4 || adv[5];
	assign adv[3]   = !vld_s3 || adv[4];
	assign adv[2]   = !vld_s2 || adv[3];
	assign adv[1]   = !vld_s1 || adv[2];
	assign in_ready = adv[1];
	assign out_valid = vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= in_valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
			if (adv[8]) vld_s8 <= vld_s7;
			if (adv[9]) vld_s9 <= vld_s8;
		end
	end

	// stage 1: bias the time so that the day count is always positive
	assign tp_in = {epoch_seconds[39], epoch_seconds} + es2cd_pkg::OFF_SEC;

	// stage 2: 86400 = 128 * 675, split the divide by 675 into two partial products
	assign x_in  = tp_s1[40:7];
	assign phi_c = 52'(x_in[33:17]) * 52'(es2cd_pkg::RCP_675);
	assign plo_c = 52'(x_in[16:0]) * 52'(es2cd_pkg::RCP_675);

	// stage 3: biased day count
	assign prod_c = {phi_s2, 17'd0} + 69'(plo_s2);

	// stage 4: second of day, era and week quotient
	assign r675_c = x_s3 - 34'(z_s3) * 34'(es2cd_pkg::DIV_675);
	assign pera_c = 49'(z_s3) * 49'(es2cd_pkg::RCP_ERA);
	assign n7_c   = z_s3 + 24'd3;   // biased day zero is a wednesday, weekday three counting from sunday
	assign pwd_c  = 49'(n7_c) * 49'(es2cd_pkg::RCP_7);

	// stage 5: day of era, weekday, minute of day
	assign doe_c  = z_s4 - 24'(era_s4) * 24'(es2cd_pkg::DAYS_PER_ERA);
	assign wd_c   = z_s4 + 24'd3 - 24'(q7_s4) * 24'd7;
	assign pmin_c = 35'(sec_s4) * 35'(es2cd_pkg::RCP_60S);

	// stage 6: leap corrections of the era, hour and second
	assign pa_c  = 37'(doe_s5) * 37'(es2cd_pkg::RCP_1460);
	assign pb_c  = 37'(doe_s5) * 37'(es2cd_pkg::RCP_36524);
	assign n_c   = doe_s5 - 18'(pa_c[35:29]) + 18'(pb_c[36:34])
		- 18'(doe_s5 == es2cd_pkg::LAST_DOE);
	assign ph_c  = 23'(mins_s5) * 23'(es2cd_pkg::RCP_60M);
	assign sec_c = sec_s5 - 17'(mins_s5) * 17'd60;

	// stage 7: year of era and minute
	assign py_c     = 37'(n_s6) * 37'(es2cd_pkg::RCP_365);
	assign minute_c = mins_s6 - 11'(hour_s6) * 11'd60;

	// stage 8: day of march-based year
	assign q100_c = 2'(yoe_s7 >= 9'd100) + 2'(yoe_s7 >= 9'd200) + 2'(yoe_s7 >= 9'd300);
	assign base_c = 18'(yoe_s7) * 18'd365 + 18'(yoe_s7[8:2]) - 18'(q100_c);
	assign doy_c  = doe_s7 - base_c;
	assign leap_c = (yoe_s7[1:0] == 2'd0) && (yoe_s7 != 9'd100) && (yoe_s7 != 9'd200)
		&& (yoe_s7 != 9'd300);

	// stage 9: month from the start table, thermometer to binary, then day of month, day of year and year
	always_comb begin
		for (int i = 1; i < 12; i++) begin
			ge_c[i] = doy_s8 >= es2cd_pkg::MONTH_START[i];
		end
	end

	assign mp_c[3] = ge_c[8];
	assign mp_c[2] = ge_c[4] & !ge_c[8];
	assign mp_c[1] = (ge_c[2] & !ge_c[4]) | (ge_c[6] & !ge_c[8]) | ge_c[10];
	assign mp_c[0] = (ge_c[1] & !ge_c[2]) | (ge_c[3] & !ge_c[4]) | (ge_c[5] & !ge_c[6])
		| (ge_c[7] & !ge_c[8]) | (ge_c[9] & !ge_c[10]) | ge_c[11];

	assign jan_c   = mp_c >= es2cd_pkg::MP_JAN;
	assign mday_c  = doy_s8 - es2cd_pkg::MONTH_START[mp_c] + 9'd1;
	assign month_c = jan_c ? mp_c - es2cd_pkg::MP_JAN : mp_c + 4'd2;
	assign yday_c  = jan_c ? doy_s8 - es2cd_pkg::MARCH_DOY_JAN1
		: doy_s8 + es2cd_pkg::DAYS_BEFORE_MARCH + 9'(leap_s8);
	assign year_c  = 16'(yoe_s8) + 16'(era_s8) * 16'd400 + 16'(jan_c) - es2cd_pkg::YEAR_BIAS;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			tp_s1 <= tp_in;
		end
		if (adv[2]) begin
			phi_s2 <= phi_c;
			plo_s2 <= plo_c;
			x_s2   <= x_in;
			lo7_s2 <= tp_s1[6:0];
		end
		if (adv[3]) begin
			z_s3   <= prod_c[67:44];
			x_s3   <= x_s2;
			lo7_s3 <= lo7_s2;
		end
		if (adv[4]) begin
			z_s4   <= z_s3;
			sec_s4 <= {r675_c[9:0], lo7_s3};
			era_s4 <= pera_c[48:42];
			q7_s4  <= pwd_c[47:27];
		end
		if (adv[5]) begin
			doe_s5  <= doe_c[17:0];
			wd_s5   <= wd_c[2:0];
			mins_s5 <= pmin_c[33:23];
			sec_s5  <= sec_s4;
			era_s5  <= era_s4;
		end
		if (adv[6]) begin
			n_s6      <= n_c;
			doe_s6    <= doe_s5;
			era_s6    <= era_s5;
			wd_s6     <= wd_s5;
			mins_s6   <= mins_s5;
			hour_s6   <= ph_c[21:17];
			second_s6 <= sec_c[5:0];
		end
		if (adv[7]) begin
			yoe_s7    <= py_c[35:27];
			doe_s7    <= doe_s6;
			era_s7    <= era_s6;
			wd_s7     <= wd_s6;
			hour_s7   <= hour_s6;
			minute_s7 <= minute_c[5:0];
			second_s7 <= second_s6;
		end
		if (adv[8]) begin
			doy_s8    <= doy_c[8:0];
			leap_s8   <= leap_c;
			yoe_s8    <= yoe_s7;
			era_s8    <= era_s7;
			wd_s8     <= wd_s7;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			second_s8 <= second_s7;
		end
		if (adv[9]) begin
			year_s9   <= year_c;
			month_s9  <= month_c;
			mday_s9   <= mday_c[4:0];
			yday_s9   <= yday_c;
			wd_s9     <= wd_s8;
			hour_s9   <= hour_s8;
			minute_s9 <= minute_s8;
			second_s9 <= second_s8;
		end
	end

	assign hour_of_day      = hour_s9;
	assign minute_of_hour   = minute_s9;
	assign second_of_minute = second_s9;
	assign weekday          = wd_s9;
	assign years_since_1900 = year_s9;
	assign month_index      = month_s9;
	assign day_of_month     = mday_s9;
	assign day_of_year      = yday_s9;

	// a free output side must never back up the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// reciprocal quotients stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59)
			&& (second_of_minute <= 6'd59) && (weekday <= 3'd6))
		else $error("time of day or weekday out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_index <= 4'd11) && (day_of_month != 5'd0)
			&& (day_of_year <= 9'd365))
		else $error("date field out of range");

	// january ties day of year to day of month
	a_jan_yday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (month_index == es2cd_pkg::MONTH_JAN)
			|-> day_of_year == 9'(day_of_month) - 9'd1)
		else $error("january day of year mismatch");

endmodule
`default_nettype wire
